// ----- sv/button_debounce_long_press_unit_defines.svh -----
// Assertion macros used by the port level checker of the button debounce unit.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BDLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

// ----- sv/bdlp_pkg.sv -----
// Types and constants shared by the button debounce and long press unit.
`timescale 1ns / 1ps
`default_nettype none
package bdlp_pkg;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS     = 8'd1;

  localparam logic [THRESH_W-1:0] DEBOUNCE_MS_RST = 16'd20;
  localparam logic [THRESH_W-1:0] LONG_MS_RST     = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_DEBOUNCE     = 2'd1,
    PH_WAIT_LONG    = 2'd2,
    PH_WAIT_RELEASE = 2'd3
  } bdlp_phase_t;

  typedef struct packed {
    logic [THRESH_W-1:0] debounce_ms;
    logic [THRESH_W-1:0] long_ms;
  } bdlp_cfg_t;

  typedef struct packed {
    logic        short_press;
    logic        long_press;
    bdlp_phase_t phase;
  } bdlp_result_t;

endpackage
`default_nettype wire

// ----- sv/bdlp_cfg.sv -----
// Configuration register file holding the debounce and long press thresholds.
`timescale 1ns / 1ps
`default_nettype none
module bdlp_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 wr_en,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [bdlp_pkg::THRESH_W-1:0]        wr_data,
  output bdlp_pkg::bdlp_cfg_t                       cfg
);

  bdlp_pkg::bdlp_cfg_t cfg_r;
  bdlp_pkg::bdlp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        bdlp_pkg::REG_DEBOUNCE_MS: cfg_nxt.debounce_ms = wr_data;
        bdlp_pkg::REG_LONG_MS:     cfg_nxt.long_ms     = wr_data;
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= bdlp_pkg::DEBOUNCE_MS_RST;
      cfg_r.long_ms     <= bdlp_pkg::LONG_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- sv/bdlp_fsm.sv -----
// Press tracking state machine with start timestamp and elapsed time compares.
`timescale 1ns / 1ps
`default_nettype none
module bdlp_fsm (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step_en,
  input  wire logic                               button_level,
  input  wire logic [bdlp_pkg::STAMP_W-1:0]       now_ms,
  input  wire bdlp_pkg::bdlp_cfg_t                cfg,
  output bdlp_pkg::bdlp_result_t                  result
);

  bdlp_pkg::bdlp_phase_t            phase_r;
  bdlp_pkg::bdlp_phase_t            phase_nxt;
  logic [bdlp_pkg::STAMP_W-1:0]     stamp_r;
  logic [bdlp_pkg::STAMP_W-1:0]     stamp_nxt;
  logic [bdlp_pkg::STAMP_W-1:0]     elapsed;
  logic                             pressed;
  logic                             debounce_met;
  logic                             long_met;

  assign pressed      = !button_level;
  assign elapsed      = now_ms - stamp_r;
  assign debounce_met = elapsed >= {{(bdlp_pkg::STAMP_W-bdlp_pkg::THRESH_W){1'b0}},
                                    cfg.debounce_ms};
  assign long_met     = elapsed >= {{(bdlp_pkg::STAMP_W-bdlp_pkg::THRESH_W){1'b0}},
                                    cfg.long_ms};

  always_comb begin
    phase_nxt          = phase_r;
    stamp_nxt          = stamp_r;
    result.short_press = 1'b0;
    result.long_press  = 1'b0;
    unique case (phase_r)
      bdlp_pkg::PH_IDLE: begin
        if (pressed) begin
          phase_nxt = bdlp_pkg::PH_DEBOUNCE;
          stamp_nxt = now_ms;
        end
      end
      bdlp_pkg::PH_DEBOUNCE: begin
        // A release here leaves the phase and the start time untouched.
        if (pressed && debounce_met) begin
          phase_nxt = bdlp_pkg::PH_WAIT_LONG;
          stamp_nxt = now_ms;
        end
      end
      bdlp_pkg::PH_WAIT_LONG: begin
        if (!pressed) begin
          result.short_press = 1'b1;
          phase_nxt          = bdlp_pkg::PH_IDLE;
        end else if (long_met) begin
          result.long_press = 1'b1;
          phase_nxt         = bdlp_pkg::PH_WAIT_RELEASE;
          stamp_nxt         = '0;
        end
      end
      bdlp_pkg::PH_WAIT_RELEASE: begin
        if (!pressed) begin
          phase_nxt = bdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = bdlp_pkg::PH_IDLE;
      end
    endcase
    result.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bdlp_pkg::PH_IDLE;
      stamp_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/button_debounce_long_press_unit.sv -----
// Top level of the button debounce and long press unit.
// Each input transaction is one poll of an active-low button with a millisecond
// timestamp, and it yields exactly one output transaction carrying the short
// press and long press pulses and the phase after the poll. A poll is captured
// in an input register and stepped through the phase machine into an output
// register; one transaction is taken every cycle while the output side keeps
// up. The phase and start time registers form the feedback loop of the phase
// machine. Thresholds are written over the configuration port (index 0
// debounce time, index 1 long press time); the user must write them only while
// no poll is in flight, which the block itself does not enforce. Other indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_long_press_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_button_level,
  input  wire logic [bdlp_pkg::STAMP_W-1:0]        in_now_ms,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_short_press,
  output logic                                     out_long_press,
  output logic [1:0]                               out_button_phase,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdlp_pkg::THRESH_W-1:0]       cfg_data
);

  logic                             in_valid_r;
  logic                             level_r;
  logic [bdlp_pkg::STAMP_W-1:0]     now_r;
  logic                             out_valid_r;
  bdlp_pkg::bdlp_result_t           result_r;
  bdlp_pkg::bdlp_result_t           step_result;
  bdlp_pkg::bdlp_cfg_t              cfg;
  logic                             out_free;
  logic                             step_en;
  logic                             in_take;

  assign out_free  = !out_valid_r || out_ready;
  assign step_en   = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  bdlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bdlp_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .button_level (level_r),
    .now_ms       (now_r),
    .cfg          (cfg),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      level_r <= in_button_level;
      now_r   <= in_now_ms;
    end
    if (step_en) begin
      result_r <= step_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_short_press  = result_r.short_press;
  assign out_long_press   = result_r.long_press;
  assign out_button_phase = result_r.phase;

endmodule
`default_nettype wire

// ----- sv/bdlp_checker.sv -----
// Port level checker for the button debounce unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_long_press_unit_defines.svh"
module bdlp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_short_press,
  input wire logic       out_long_press,
  input wire logic [1:0] out_button_phase
);

  `BDLP_ASSERT_NOW(a_one_pulse, clk, rst_n, out_valid, !(out_short_press && out_long_press))
  `BDLP_ASSERT_NOW(a_short_idle, clk, rst_n, out_valid && out_short_press, out_button_phase == bdlp_pkg::PH_IDLE)
  `BDLP_ASSERT_NOW(a_long_release, clk, rst_n, out_valid && out_long_press, out_button_phase == bdlp_pkg::PH_WAIT_RELEASE)
  `BDLP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_button_phase) && $stable(out_short_press) && $stable(out_long_press))

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_short_press  (out_short_press),
  .out_long_press   (out_long_press),
  .out_button_phase (out_button_phase)
);
`default_nettype wire

// ----- tb/tb_button_debounce_long_press_unit.sv -----
// Self-checking testbench for the button debounce and long press unit.
`timescale 1ns / 1ps
module tb_button_debounce_long_press_unit;

  localparam logic [bdlp_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_button_level = 1'b1;
  logic [bdlp_pkg::STAMP_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_short_press;
  logic out_long_press;
  logic [1:0] out_button_phase;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bdlp_pkg::THRESH_W-1:0] cfg_data = '0;

  bdlp_pkg::bdlp_phase_t btn_phase = bdlp_pkg::PH_IDLE;
  logic [bdlp_pkg::STAMP_W-1:0] press_stamp = '0;
  logic [bdlp_pkg::THRESH_W-1:0] debounce_thr = bdlp_pkg::DEBOUNCE_MS_RST;
  logic [bdlp_pkg::THRESH_W-1:0] long_thr = bdlp_pkg::LONG_MS_RST;
  bdlp_pkg::bdlp_result_t pending_results[$];

  int mismatches = 0;
  int polls_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_window = 0;
  int rx_mode = 0;
  logic [bdlp_pkg::STAMP_W-1:0] clock_ms = '0;
  int step_span = 1;

  button_debounce_long_press_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_button_level(in_button_level),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_short_press(out_short_press),
    .out_long_press(out_long_press),
    .out_button_phase(out_button_phase),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls on a pattern chosen per window, or holds off entirely when asked.
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (rx_window == 0) begin
      rx_window = $urandom_range(16, 80);
      rx_mode = $urandom_range(0, 3);
    end
    rx_window--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycle_count % 5 != 0);
      endcase
    end
  end

  function automatic bdlp_pkg::bdlp_result_t next_button_result(
      input logic level, input logic [bdlp_pkg::STAMP_W-1:0] stamp);
    bdlp_pkg::bdlp_result_t res;
    logic pressed;
    logic [bdlp_pkg::STAMP_W-1:0] held;
    pressed = !level;
    held = stamp - press_stamp;
    res.short_press = 1'b0;
    res.long_press = 1'b0;
    if (pressed && btn_phase == bdlp_pkg::PH_IDLE) begin
      btn_phase = bdlp_pkg::PH_DEBOUNCE;
      press_stamp = stamp;
    end else if (btn_phase != bdlp_pkg::PH_IDLE) begin
      if (pressed && btn_phase == bdlp_pkg::PH_DEBOUNCE &&
          held >= {16'd0, debounce_thr}) begin
        btn_phase = bdlp_pkg::PH_WAIT_LONG;
        press_stamp = stamp;
      end else if (!pressed && btn_phase == bdlp_pkg::PH_WAIT_LONG) begin
        res.short_press = 1'b1;
        btn_phase = bdlp_pkg::PH_IDLE;
      end else if (pressed && btn_phase == bdlp_pkg::PH_WAIT_LONG &&
                   held >= {16'd0, long_thr}) begin
        res.long_press = 1'b1;
        btn_phase = bdlp_pkg::PH_WAIT_RELEASE;
        press_stamp = '0;
      end
    end
    if (btn_phase == bdlp_pkg::PH_WAIT_RELEASE && !pressed) btn_phase = bdlp_pkg::PH_IDLE;
    res.phase = btn_phase;
    return res;
  endfunction

  always @(posedge clk) begin
    bdlp_pkg::bdlp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result short=%0b long=%0b phase=%0d", $time,
                 out_short_press, out_long_press, out_button_phase);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_short_press !== want.short_press) begin
          $display("%0t: short_press expected %0b actual %0b", $time,
                   want.short_press, out_short_press);
          mismatches++;
        end
        if (out_long_press !== want.long_press) begin
          $display("%0t: long_press expected %0b actual %0b", $time,
                   want.long_press, out_long_press);
          mismatches++;
        end
        if (out_button_phase !== want.phase) begin
          $display("%0t: button_phase expected %0d actual %0d", $time,
                   want.phase, out_button_phase);
          mismatches++;
        end
      end
    end
  end

  task automatic send_poll(input logic level, input logic [bdlp_pkg::STAMP_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_button_level <= level;
    in_now_ms <= stamp;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(next_button_result(level, stamp));
    polls_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdlp_pkg::THRESH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bdlp_pkg::REG_DEBOUNCE_MS) debounce_thr = data;
    else if (idx == bdlp_pkg::REG_LONG_MS) long_thr = data;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [bdlp_pkg::THRESH_W-1:0] deb,
                                input logic [bdlp_pkg::THRESH_W-1:0] lng);
    wait_drain();
    write_reg(bdlp_pkg::REG_DEBOUNCE_MS, deb);
    write_reg(bdlp_pkg::REG_LONG_MS, lng);
    step_span = (int'(deb) + int'(lng)) / 6 + 1;
    clock_ms = $urandom();
  endtask

  // Time moves forward by a random step, now and then lands on a threshold edge or jumps.
  task automatic poll_at(input logic level);
    logic [bdlp_pkg::STAMP_W-1:0] thr;
    if ($urandom_range(0, 39) == 0) begin
      clock_ms = $urandom();
    end else if ($urandom_range(0, 3) == 0 &&
                 (btn_phase == bdlp_pkg::PH_DEBOUNCE ||
                  btn_phase == bdlp_pkg::PH_WAIT_LONG)) begin
      thr = (btn_phase == bdlp_pkg::PH_DEBOUNCE) ? {16'd0, debounce_thr} : {16'd0, long_thr};
      clock_ms = press_stamp + thr + $urandom_range(0, 2) - 1;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_span);
    end
    send_poll(level, clock_ms);
  endtask

  task automatic press_sequence();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        clock_ms = $urandom();
        send_poll(1'($urandom_range(0, 1)), clock_ms);
      end
    end else begin
      repeat ($urandom_range(0, 2)) poll_at(1'b1);
      repeat ($urandom_range(0, 3)) poll_at(1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 12)) poll_at(1'b0);
      repeat ($urandom_range(1, 2)) poll_at(1'b1);
    end
  endtask

  task automatic run_presses(input int count);
    int goal;
    goal = polls_sent + count;
    while (polls_sent < goal) press_sequence();
  endtask

  task automatic test_default_presses();
    send_poll(1'b1, 32'd1000);
    send_poll(1'b0, 32'd1000);
    send_poll(1'b0, 32'd1019);
    send_poll(1'b0, 32'd1020);
    send_poll(1'b1, 32'd1500);
    send_poll(1'b0, 32'd2000);
    send_poll(1'b1, 32'd2005);
    send_poll(1'b0, 32'd2020);
    send_poll(1'b0, 32'd4019);
    send_poll(1'b0, 32'd4020);
    send_poll(1'b0, 32'd4500);
    send_poll(1'b1, 32'd4501);
  endtask

  task automatic test_threshold_extremes();
    set_thresholds(16'd0, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0000);
    send_poll(1'b1, 32'h0000_0000);
    set_thresholds(16'hFFFF, 16'hFFFF);
    send_poll(1'b0, 32'hFFFF_FFF0);
    send_poll(1'b0, 32'h0000_FFEF);
    send_poll(1'b0, 32'h0000_0010);
    send_poll(1'b1, 32'h0001_0000);
  endtask

  task automatic test_random_presses();
    set_thresholds(bdlp_pkg::DEBOUNCE_MS_RST, bdlp_pkg::LONG_MS_RST);
    run_presses(150);
    set_thresholds(16'd0, 16'd0);
    run_presses(150);
    set_thresholds(16'hFFFF, 16'hFFFF);
    run_presses(150);
    set_thresholds(16'd3, 16'd17);
    run_presses(150);
    set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    run_presses(150);
    set_thresholds(16'd1, 16'hFFFF);
    run_presses(150);
    set_thresholds(16'hFFFF, 16'd0);
    run_presses(150);
  endtask

  task automatic test_output_backpressure();
    set_thresholds(16'd5, 16'd40);
    hold_asks++;
    no_gaps = 1'b1;
    run_presses(80);
    no_gaps = 1'b0;
    wait_drain();
    run_presses(40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_presses();
    test_threshold_extremes();
    test_random_presses();
    test_output_backpressure();
    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
